FILE: sv/utfd_pkg.sv
package utfd_pkg;

    localparam int UnitsMax   = 3;
    localparam int QueueDepth = 4;

    localparam logic [15:0] UnitBom      = 16'hFEFF;
    localparam logic [15:0] UnitQuestion = 16'd63;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        out_last;
    } out_item_t;

    // Up to three words produced by one byte, packed from index 0.
    typedef struct packed {
        out_item_t [UnitsMax-1:0] unit;
        logic      [1:0]          cnt;
    } push_bundle_t;

endpackage

FILE: sv/utfd_core.sv
module utfd_core
    import utfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  in_item_t     item,
    output push_bundle_t push
);

    logic [15:0] partial_reg;
    logic [15:0] partial_next;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic        first_reg;
    logic        first_next;

    logic [7:0]  b;
    logic        is_cont;
    logic        is_ascii;
    logic        is_lead2;
    logic        is_lead3;
    logic        cut;
    logic [1:0]  p1;
    logic [15:0] pc1;
    logic        f1;
    logic [1:0]  p2;
    logic [15:0] pc2;
    logic        f2;
    logic [15:0] merged;
    logic [15:0] char_unit;
    logic        char_emit;
    logic [3:0]  cand_v;
    out_item_t [3:0] cand;

    assign b        = item.in_byte;
    assign is_ascii = !b[7];
    assign is_cont  = (b[7:6] == 2'b10);
    assign is_lead2 = (b[7:5] == 3'b110);
    assign is_lead3 = (b[7:4] == 4'b1110);

    always_comb
    begin
        // Any byte that is not a continuation closes an open sequence first.
        cut = (pend_reg != 2'd0) && !is_cont;
        p1  = cut ? 2'd0 : pend_reg;
        pc1 = cut ? 16'd0 : partial_reg;
        f1  = cut ? 1'b0 : first_reg;

        merged    = pc1 | ((p1 == 2'd2) ? {4'd0, b[5:0], 6'd0} : {10'd0, b[5:0]});
        p2        = p1;
        pc2       = pc1;
        f2        = 1'b0;
        char_emit = 1'b0;
        char_unit = {8'd0, b};

        if (is_ascii)
        begin
            char_emit = 1'b1;
        end
        else if (is_cont)
        begin
            if (p1 != 2'd0)
            begin
                p2 = p1 - 2'd1;
                if (p1 == 2'd1)
                begin
                    // A complete byte-order mark as the first character is dropped.
                    char_emit = !(f1 && (merged == UnitBom));
                    char_unit = merged;
                    pc2       = 16'd0;
                end
                else
                begin
                    pc2 = merged;
                    f2  = f1;
                end
            end
        end
        else if (is_lead2)
        begin
            pc2 = {5'd0, b[4:0], 6'd0};
            p2  = 2'd1;
        end
        else if (is_lead3)
        begin
            pc2 = {b[3:0], 12'd0};
            p2  = 2'd2;
            f2  = f1;
        end
        else
        begin
            char_emit = 1'b1;
            char_unit = UnitQuestion;
        end

        cand[0] = '{code_unit: partial_reg, out_last: 1'b0};
        cand[1] = '{code_unit: char_unit, out_last: 1'b0};
        cand[2] = '{code_unit: pc2, out_last: 1'b0};
        cand[3] = '{code_unit: 16'd0, out_last: 1'b1};
        cand_v  = {item.in_last, item.in_last && (p2 != 2'd0), char_emit, cut};

        if (item.in_last)
        begin
            partial_next = 16'd0;
            pend_next    = 2'd0;
            first_next   = 1'b1;
        end
        else
        begin
            partial_next = pc2;
            pend_next    = p2;
            first_next   = f2;
        end
    end

    // At most three of the four candidates are ever valid together.
    always_comb
    begin
        logic [2:0] k;
        k    = 3'd0;
        push = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && (k < 3'(UnitsMax)))
            begin
                push.unit[k[1:0]] = cand[i];
                k = k + 3'd1;
            end
        end
        push.cnt = k[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 16'd0;
            pend_reg    <= 2'd0;
            first_reg   <= 1'b1;
        end
        else if (advance)
        begin
            partial_reg <= partial_next;
            pend_reg    <= pend_next;
            first_reg   <= first_next;
        end
    end

endmodule

FILE: sv/utfd_result_queue.sv
module utfd_result_queue
    import utfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_en,
    input  push_bundle_t push,
    input  logic         pop,
    output logic         not_empty,
    output logic         room,
    output out_item_t    head,
    output logic [2:0]   count
);

    localparam int PtrW = $clog2(QueueDepth);

    out_item_t             slot_reg [QueueDepth];
    logic [PtrW-1:0]       wr_reg;
    logic [PtrW-1:0]       wr_next;
    logic [PtrW-1:0]       rd_reg;
    logic [PtrW-1:0]       rd_next;
    logic [2:0]            count_reg;
    logic [2:0]            count_next;
    logic [2:0]            after_pop;
    logic [1:0]            n_push;

    assign not_empty = (count_reg != 3'd0);
    assign head      = slot_reg[rd_reg];
    assign count     = count_reg;
    assign after_pop = count_reg - {2'd0, pop};
    // Room for a full three-word burst once this cycle's pop is counted.
    assign room      = (after_pop <= 3'(QueueDepth - UnitsMax));
    assign n_push    = push_en ? push.cnt : 2'd0;

    assign wr_next    = wr_reg + PtrW'(n_push);
    assign rd_next    = rd_reg + PtrW'(pop);
    assign count_next = after_pop + {1'b0, n_push};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < UnitsMax; i++)
        begin
            if (push_en && (2'(i) < push.cnt))
            begin
                slot_reg[wr_reg + PtrW'(i)] <= push.unit[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/utf8_to_ucs2_stream_decoder_unit.sv
// Path: an accepted byte is registered in the hold register, decoded and written to the result queue.
// Throughput: one byte per cycle while each byte yields at most one word and the output is
// not stalled; a byte that yields more words can stall the input, set by the single output port
// draining the four-entry result queue one word a cycle while out_stall is low.
// Reset: asynchronous, active low; decoder state returns to start of string, queue empties.
module utf8_to_ucs2_stream_decoder_unit
    import utfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic         hold_valid_reg;
    logic         hold_valid_next;
    in_item_t     hold_reg;
    logic         advance;
    logic         pop;
    logic         room;
    logic [2:0]   q_count;
    push_bundle_t push;

    assign pop     = out_valid && !out_stall;
    assign advance = hold_valid_reg && room;
    assign in_stall = hold_valid_reg && !room;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && !in_stall)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_reg <= in_data;
        end
    end

    utfd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (hold_reg),
        .push    (push)
    );

    utfd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .pop       (pop),
        .not_empty (out_valid),
        .room      (room),
        .head      (out_data),
        .count     (q_count)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 3'(QueueDepth))
        else $error("result queue over capacity");

    a_drain_only_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("output word vanished without being taken");

    a_terminator_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_last |-> out_data.code_unit == 16'd0)
        else $error("terminator word is not zero");

    a_burst_fits: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (q_count - 3'(pop) + 3'(push.cnt)) <= 3'(QueueDepth))
        else $error("burst overflows result queue");

endmodule

FILE: tb/sv/tb_utf8_to_ucs2_stream_decoder_unit.sv
module tb_utf8_to_ucs2_stream_decoder_unit;
    import utfd_pkg::*;

    localparam logic [7:0]  BomLead  = 8'hEF;
    localparam logic [7:0]  BomMid   = 8'hBB;
    localparam logic [7:0]  BomTail  = 8'hBF;
    localparam logic [7:0]  ContMark = 8'h80;
    localparam logic [7:0]  Lead2    = 8'hC0;
    localparam logic [7:0]  Lead3    = 8'hE0;
    localparam logic [7:0]  Lead4    = 8'hF0;
    localparam logic [15:0] UnitEnd  = 16'h0000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    logic        tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;
    int          errors     = 0;
    out_item_t   pending_units[$];
    logic [7:0]  text_buf[$];

    // Shadow of the decoder state.
    logic [15:0] dec_partial = '0;
    logic [1:0]  dec_pending = '0;
    logic        dec_first   = 1'b1;

    utf8_to_ucs2_stream_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb_utf8_to_ucs2_stream_decoder_unit: FAIL");
        $finish;
    end

    function automatic void expect_unit(input logic [15:0] unit, input logic fin);
        out_item_t w;
        w.code_unit = unit;
        w.out_last  = fin;
        pending_units.push_back(w);
    endfunction

    function automatic void decode_byte(input logic [7:0] octet, input logic fin);
        // Anything but a continuation cuts short an open sequence.
        if (dec_pending != 2'd0 && octet[7:6] != 2'b10)
        begin
            expect_unit(dec_partial, 1'b0);
            dec_partial = '0;
            dec_pending = 2'd0;
            dec_first   = 1'b0;
        end
        if (!octet[7])
        begin
            expect_unit({8'h00, octet}, 1'b0);
            dec_first = 1'b0;
        end
        else if (octet[7:6] == 2'b10)
        begin
            if (dec_pending != 2'd0)
            begin
                if (dec_pending == 2'd2)
                    dec_partial = dec_partial | {4'b0, octet[5:0], 6'b0};
                else
                    dec_partial = dec_partial | {10'b0, octet[5:0]};
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == 2'd0)
                begin
                    if (!(dec_first && dec_partial == UnitBom))
                        expect_unit(dec_partial, 1'b0);
                    dec_first   = 1'b0;
                    dec_partial = '0;
                end
            end
            else
                dec_first = 1'b0;
        end
        else if (octet[7:5] == 3'b110)
        begin
            dec_partial = {5'b0, octet[4:0], 6'b0};
            dec_pending = 2'd1;
            dec_first   = 1'b0;
        end
        else if (octet[7:4] == 4'b1110)
        begin
            // The first-character flag survives: this may open a byte-order mark.
            dec_partial = {octet[3:0], 12'b0};
            dec_pending = 2'd2;
        end
        else
        begin
            expect_unit(UnitQuestion, 1'b0);
            dec_first = 1'b0;
        end
        if (fin)
        begin
            if (dec_pending != 2'd0)
                expect_unit(dec_partial, 1'b0);
            expect_unit(UnitEnd, 1'b1);
            dec_partial = '0;
            dec_pending = 2'd0;
            dec_first   = 1'b1;
        end
    endfunction

    task automatic send_byte(input logic [7:0] octet, input logic fin);
        in_item_t item;
        item.in_byte = octet;
        item.in_last = fin;
        while (tx_idle_on && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(octet, fin);
    endtask

    // Sends the buffered string with the final flag on its last byte.
    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic close_phase();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return ContMark | 8'($urandom_range(0, 63));
    endfunction

    function automatic void append_random_char();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 35)
            text_buf.push_back(8'($urandom_range(0, 127)));
        else if (kind < 55)
        begin
            text_buf.push_back(Lead2 | 8'($urandom_range(0, 31)));
            text_buf.push_back(cont_byte());
        end
        else if (kind < 75)
        begin
            text_buf.push_back(Lead3 | 8'($urandom_range(0, 15)));
            text_buf.push_back(cont_byte());
            text_buf.push_back(cont_byte());
        end
        else if (kind < 80)
        begin
            text_buf.push_back(Lead4 | 8'($urandom_range(0, 7)));
            text_buf.push_back(cont_byte());
            text_buf.push_back(cont_byte());
            text_buf.push_back(cont_byte());
        end
        else if (kind < 85)
        begin
            text_buf.push_back(BomLead);
            text_buf.push_back(BomMid);
            text_buf.push_back(BomTail);
        end
        else if (kind < 92)
        begin
            // A sequence that stops early.
            if ($urandom_range(0, 1) == 0)
                text_buf.push_back(Lead2 | 8'($urandom_range(0, 31)));
            else
            begin
                text_buf.push_back(Lead3 | 8'($urandom_range(0, 15)));
                if ($urandom_range(0, 1) == 0)
                    text_buf.push_back(cont_byte());
            end
        end
        else
            text_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_ascii_and_zero();
        text_buf = '{8'h00, 8'h41, 8'h7F};
        send_text();
        close_phase();
    endtask

    task automatic test_multibyte_and_repairs();
        // Two- and three-byte characters, a cut-short sequence, a four-byte lead with a
        // stray continuation, an invalid byte and a string that ends inside a sequence.
        text_buf = '{8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC, 8'hC3, 8'h41,
                     8'hF0, 8'h9F, 8'hFF, 8'hE2, 8'h82};
        send_text();
        close_phase();
    endtask

    task automatic test_byte_order_mark();
        // Only the first mark of a string is dropped.
        text_buf = '{BomLead, BomMid, BomTail, BomLead, BomMid, BomTail};
        send_text();
        text_buf = '{BomLead, BomMid};
        send_text();
        // A stray continuation first spoils the drop.
        text_buf = '{BomTail, BomLead, BomMid, BomTail};
        send_text();
        close_phase();
    endtask

    task automatic test_random_strings(input int target);
        int sent;
        int n_chars;
        int i;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                text_buf.push_back(BomLead);
                text_buf.push_back(BomMid);
                text_buf.push_back(BomTail);
            end
            n_chars = $urandom_range(1, 10);
            for (i = 0; i < n_chars; i++)
                append_random_char();
            sent += text_buf.size();
            send_text();
        end
        close_phase();
    endtask

    task automatic test_without_idling(input int target);
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;
        @(posedge clk);
        test_random_strings(target);
        tx_idle_on <= 1'b1;
        rx_idle_on <= 1'b1;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_words
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_units.size() == 0)
            begin
                $error("unexpected word: code_unit %h out_last %b",
                       out_data.code_unit, out_data.out_last);
                errors++;
            end
            else
            begin
                want = pending_units.pop_front();
                if (out_data.code_unit !== want.code_unit)
                begin
                    $error("code_unit: expected %h, got %h", want.code_unit,
                           out_data.code_unit);
                    errors++;
                end
                if (out_data.out_last !== want.out_last)
                begin
                    $error("out_last: expected %b, got %b", want.out_last,
                           out_data.out_last);
                    errors++;
                end
            end
        end
        out_stall <= rst_n && rx_idle_on && ($urandom_range(0, 99) < 27);
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii_and_zero();
        test_multibyte_and_repairs();
        test_byte_order_mark();
        test_random_strings(135);
        test_without_idling(60);
        test_random_strings(25);
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_units.size() == 0)
            $display("tb_utf8_to_ucs2_stream_decoder_unit: PASS");
        else
            $display("tb_utf8_to_ucs2_stream_decoder_unit: FAIL");
        $finish;
    end

endmodule
